// ===== hdl/fifo_replacement_cache_top_assert.svh =====
// Assertion macros shared by the cache checker.
`ifndef FIFO_REPLACEMENT_CACHE_TOP_ASSERT_SVH
`define FIFO_REPLACEMENT_CACHE_TOP_ASSERT_SVH

// Property checked only outside reset.
`define FRC_ASSERT_RUN(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define FRC_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/frc_pkg.sv =====
// Shared types and constants of the FIFO-replacement cache.
package frc_pkg;

    localparam int CAP_W       = 5;
    localparam int KIND_W      = 2;
    localparam int CNT_W       = 32;
    localparam int ENTRIES_DEF = 16;
    localparam int DATA_W_DEF  = 32;
    localparam int KEY_W_DEF   = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_LOAD   = 2'd1,
        KIND_CLEAR  = 2'd2
    } t_kind;

    // Store update commands from the control path to the entry store.
    typedef struct packed {
        logic clear;
        logic evict;
        logic insert;
        logic update;
    } t_cam_cmd;

endpackage

// ===== hdl/frc_cam.sv =====
// Fully associative entry store: keys, data words, occupancy and parallel compare.
module frc_cam #(
    parameter int ENTRIES    = frc_pkg::ENTRIES_DEF,
    parameter int KEY_WIDTH  = frc_pkg::KEY_W_DEF,
    parameter int DATA_WIDTH = frc_pkg::DATA_W_DEF,
    parameter int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  frc_pkg::t_cam_cmd     i_cmd,
    input  logic [KEY_WIDTH-1:0]  i_key,
    input  logic [DATA_WIDTH-1:0] i_data,
    input  logic [IDX_W-1:0]      i_ins_idx,
    input  logic [IDX_W-1:0]      i_old_idx,
    output logic                  o_hit,
    output logic [DATA_WIDTH-1:0] o_hit_data,
    output logic [KEY_WIDTH-1:0]  o_old_key
);
    import frc_pkg::*;

    logic [KEY_WIDTH-1:0]  r_key  [ENTRIES];
    logic [DATA_WIDTH-1:0] r_data [ENTRIES];
    logic [ENTRIES-1:0]    r_occ;
    logic [ENTRIES-1:0]    w_match;

    // Compare the key against every occupied slot, select the matching word
    always_comb begin
        o_hit_data = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_match[i] = r_occ[i] && (r_key[i] == i_key);
            if (w_match[i]) begin
                o_hit_data = o_hit_data | r_data[i];
            end
        end
    end

    assign o_hit     = |w_match;
    assign o_old_key = r_key[i_old_idx];

    // Occupancy: clear all, drop the oldest, mark the new slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_occ <= '0;
        end else begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (i_cmd.insert && i_ins_idx == IDX_W'(i)) begin
                    r_occ[i] <= 1'b1;
                end else if (i_cmd.evict && i_old_idx == IDX_W'(i)) begin
                    r_occ[i] <= 1'b0;
                end
            end
        end
    end

    // Write key and data on insert, data alone on update of a present key
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (i_cmd.insert && i_ins_idx == IDX_W'(i)) begin
                r_key[i]  <= i_key;
                r_data[i] <= i_data;
            end else if (i_cmd.update && w_match[i]) begin
                r_data[i] <= i_data;
            end
        end
    end

endmodule

// ===== hdl/fifo_replacement_cache_top.sv =====
// Fully associative cache with first-in first-out replacement, stream ports.
//
// One word is taken per clock and one result word leaves per clock when the
// output side keeps taking them. A word passes an input register, then one
// parallel compare of its key against all entries decides hit, update, insert
// or eviction, and the result register holds the answer. The entry store
// updates at the same edge as the result register, so the next word sees the
// effect of this one. No clearing pass runs after reset; the store is ready at
// once. Capacity is taken from the configuration channel, clamped to
// 1..ENTRIES. The user must write it only while idle; the block does not check.
module fifo_replacement_cache_top #(
    parameter int ENTRIES    = frc_pkg::ENTRIES_DEF,
    parameter int KEY_WIDTH  = frc_pkg::KEY_W_DEF,
    parameter int DATA_WIDTH = frc_pkg::DATA_W_DEF,
    parameter int IN_W       = ((KEY_WIDTH + DATA_WIDTH + 7) / 8) * 8,
    parameter int OUT_W      = ((DATA_WIDTH + KEY_WIDTH + 2 * frc_pkg::CNT_W + 7) / 8) * 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration: capacity
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [frc_pkg::CAP_W-1:0]  i_cfg_data,
    // input stream
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [IN_W-1:0]            i_s_axis_tdata,  // key, data_in
    input  logic [frc_pkg::KIND_W-1:0] i_s_axis_tuser,  // kind
    // result stream
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [OUT_W-1:0]           o_m_axis_tdata,  // read_data, evicted_key,
                                                        // hit_count, miss_count
    output logic [1:0]                 o_m_axis_tuser   // hit, evicted
);
    import frc_pkg::*;

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FILL_W = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;
    localparam int POS_W  = FILL_W + 1;

    // input register
    logic                  r_in_valid;
    logic [KIND_W-1:0]     r_kind;
    logic [KEY_WIDTH-1:0]  r_key;
    logic [DATA_WIDTH-1:0] r_data;

    // cache control state
    logic [CAP_W-1:0]      r_cap;
    logic [IDX_W-1:0]      r_oldest, n_oldest;
    logic [FILL_W-1:0]     r_fill, n_fill;
    logic [CNT_W-1:0]      r_hit_cnt, n_hit_cnt;
    logic [CNT_W-1:0]      r_miss_cnt, n_miss_cnt;

    // result register
    logic                  r_out_valid;
    logic                  r_out_hit, n_out_hit;
    logic                  r_out_ev, n_out_ev;
    logic [DATA_WIDTH-1:0] r_out_rdata, n_out_rdata;
    logic [KEY_WIDTH-1:0]  r_out_evkey, n_out_evkey;

    logic                  w_move;
    logic                  w_hit;
    logic [DATA_WIDTH-1:0] w_hit_data;
    logic [KEY_WIDTH-1:0]  w_old_key;
    logic [CMP_W-1:0]      w_cap_x, w_ent_x, w_eff_cap;
    logic                  w_full;
    logic [POS_W-1:0]      w_pos_sum;
    logic [IDX_W-1:0]      w_ins_idx, w_oldest_inc;
    t_cam_cmd              w_cmd;

    assign w_move          = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_move;
    assign o_cfg_ready     = 1'b1;

    // Clamp capacity to 1..ENTRIES
    always_comb begin
        w_cap_x = CMP_W'(r_cap);
        w_ent_x = CMP_W'(ENTRIES);
        if (w_cap_x == '0) begin
            w_eff_cap = CMP_W'(1);
        end else if (w_cap_x > w_ent_x) begin
            w_eff_cap = w_ent_x;
        end else begin
            w_eff_cap = w_cap_x;
        end
        w_full = CMP_W'(r_fill) >= w_eff_cap;
    end

    // New entry goes behind the youngest; the same slot whether or not one is evicted
    always_comb begin
        w_pos_sum = POS_W'(r_oldest) + POS_W'(r_fill);
        if (w_pos_sum >= POS_W'(ENTRIES)) begin
            w_pos_sum = w_pos_sum - POS_W'(ENTRIES);
        end
        w_ins_idx    = w_pos_sum[IDX_W-1:0];
        w_oldest_inc = (r_oldest == IDX_W'(ENTRIES - 1)) ? '0 : r_oldest + 1'b1;
    end

    // Decide the operation for the word in the input register
    always_comb begin
        w_cmd       = '0;
        n_oldest    = r_oldest;
        n_fill      = r_fill;
        n_hit_cnt   = r_hit_cnt;
        n_miss_cnt  = r_miss_cnt;
        n_out_hit   = 1'b0;
        n_out_ev    = 1'b0;
        n_out_rdata = '0;
        n_out_evkey = '0;
        unique case (r_kind)
            KIND_LOOKUP: begin
                if (w_hit) begin
                    n_out_hit   = 1'b1;
                    n_out_rdata = w_hit_data;
                    n_hit_cnt   = (&r_hit_cnt) ? r_hit_cnt : r_hit_cnt + 1'b1;
                end else begin
                    n_miss_cnt  = (&r_miss_cnt) ? r_miss_cnt : r_miss_cnt + 1'b1;
                end
            end
            KIND_LOAD: begin
                if (w_hit) begin
                    w_cmd.update = 1'b1;
                end else begin
                    w_cmd.insert = 1'b1;
                    if (w_full) begin
                        w_cmd.evict = 1'b1;
                        n_out_ev    = 1'b1;
                        n_out_evkey = w_old_key;
                        n_oldest    = w_oldest_inc;
                    end else begin
                        n_fill      = r_fill + 1'b1;
                    end
                end
            end
            KIND_CLEAR: begin
                w_cmd.clear = 1'b1;
                n_oldest    = '0;
                n_fill      = '0;
                n_hit_cnt   = '0;
                n_miss_cnt  = '0;
            end
            default: begin
                // unused kind: report counters, change nothing
            end
        endcase
        if (!w_move) begin
            w_cmd = '0;
        end
    end

    frc_cam #(
        .ENTRIES    (ENTRIES),
        .KEY_WIDTH  (KEY_WIDTH),
        .DATA_WIDTH (DATA_WIDTH),
        .IDX_W      (IDX_W)
    ) u_cam (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_key      (r_key),
        .i_data     (r_data),
        .i_ins_idx  (w_ins_idx),
        .i_old_idx  (r_oldest),
        .o_hit      (w_hit),
        .o_hit_data (w_hit_data),
        .o_old_key  (w_old_key)
    );

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data;
        end
    end

    // Input register: take a word whenever the stage is free or moving on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_kind <= i_s_axis_tuser;
            r_key  <= i_s_axis_tdata[KEY_WIDTH-1:0];
            r_data <= i_s_axis_tdata[KEY_WIDTH +: DATA_WIDTH];
        end
    end

    // Queue pointers and counters advance with each processed word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest   <= '0;
            r_fill     <= '0;
            r_hit_cnt  <= '0;
            r_miss_cnt <= '0;
        end else if (w_move) begin
            r_oldest   <= n_oldest;
            r_fill     <= n_fill;
            r_hit_cnt  <= n_hit_cnt;
            r_miss_cnt <= n_miss_cnt;
        end
    end

    // Result register: hold while the output side stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_m_axis_tready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out_hit   <= n_out_hit;
            r_out_ev    <= n_out_ev;
            r_out_rdata <= n_out_rdata;
            r_out_evkey <= n_out_evkey;
        end
    end

    // Counters after this word travel in the result register too
    logic [CNT_W-1:0] r_out_hcnt, r_out_mcnt;

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out_hcnt <= n_hit_cnt;
            r_out_mcnt <= n_miss_cnt;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = {r_out_ev, r_out_hit};
    assign o_m_axis_tdata  = OUT_W'({r_out_mcnt, r_out_hcnt, r_out_evkey, r_out_rdata});

endmodule

// ===== hdl/frc_checker.sv =====
// Port-level checker for the cache, bound to the top level.
`include "fifo_replacement_cache_top_assert.svh"

module frc_checker #(
    parameter int KEY_WIDTH  = frc_pkg::KEY_W_DEF,
    parameter int DATA_WIDTH = frc_pkg::DATA_W_DEF,
    parameter int OUT_W      = ((DATA_WIDTH + KEY_WIDTH + 2 * frc_pkg::CNT_W + 7) / 8) * 8
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [OUT_W-1:0] o_m_axis_tdata,
    input logic [1:0]       o_m_axis_tuser
);
    import frc_pkg::*;

    localparam int HCNT_LO = DATA_WIDTH + KEY_WIDTH;

    // stalled result word holds
    `FRC_ASSERT_RUN(a_hold_stall, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "result word changed while stalled")

    // no result word right after reset
    `FRC_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "result valid after reset")

    // a hit and an eviction never come from the same word
    `FRC_ASSERT_RUN(a_hit_ev_excl, i_clk, i_rst_n, o_m_axis_tvalid |-> !(o_m_axis_tuser[0] && o_m_axis_tuser[1]), "hit and evicted both set")

    // a hit is always counted; a word without a hit reads zero data
    `FRC_ASSERT_RUN(a_hit_counted, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata[HCNT_LO +: CNT_W] != '0, "hit with zero hit count")

    `FRC_ASSERT_RUN(a_miss_zero, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata[DATA_WIDTH-1:0] == '0, "read data on a non-hit")

endmodule

bind fifo_replacement_cache_top frc_checker #(
    .KEY_WIDTH  (KEY_WIDTH),
    .DATA_WIDTH (DATA_WIDTH),
    .OUT_W      (OUT_W)
) u_frc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the FIFO-replacement cache, with stream stimulus and a result scoreboard.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import frc_pkg::*;

    localparam int                CLK_PERIOD   = 12;
    localparam int                NUM_SLOTS    = ENTRIES_DEF;
    localparam int                IN_BITS      = 64;
    localparam int                OUT_BITS     = 128;
    localparam logic [KIND_W-1:0] KIND_NOP     = 2'd3;
    localparam int                HOLD_CYCLES  = 150;
    localparam int                DRAIN_CYCLES = 6;
    localparam int                PHASE_WORDS  = 200;
    localparam int                POOL_SIZE    = 24;
    localparam int                PRED_DEPTH   = 8;
    localparam int                PRED_IDX_W   = 3;

    typedef struct packed {
        logic        hit;
        logic [31:0] read_data;
        logic        evicted;
        logic [31:0] evicted_key;
        logic [31:0] hit_count;
        logic [31:0] miss_count;
    } t_cache_result;

    typedef enum int {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_SPARSE,
        READY_PERIODIC
    } t_ready_mode;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CAP_W-1:0]    i_cfg_data;
    logic                i_s_axis_tvalid;
    logic                o_s_axis_tready;
    logic [IN_BITS-1:0]  i_s_axis_tdata;   // key, data_in
    logic [KIND_W-1:0]   i_s_axis_tuser;   // kind
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready;
    logic [OUT_BITS-1:0] o_m_axis_tdata;   // read_data, evicted_key, hit_count, miss_count
    logic [1:0]          o_m_axis_tuser;   // hit, evicted

    // hold-off requests from the stimulus side, served by the receiver
    int hold_asked  = 0;
    int hold_served = 0;
    int error_count = 0;

    // Shadow copy of the cache contents
    logic [31:0]      model_keys [NUM_SLOTS];
    logic [31:0]      model_data [NUM_SLOTS];
    bit               model_used [NUM_SLOTS];
    int unsigned      model_head;
    int unsigned      model_fill;
    logic [31:0]      model_hits;
    logic [31:0]      model_misses;
    logic [CAP_W-1:0] model_capacity;

    // Predicted results in acceptance order; sender writes, checker reads
    t_cache_result         pred_buf [PRED_DEPTH];
    logic [PRED_IDX_W-1:0] pred_wr = '0;
    logic [PRED_IDX_W-1:0] pred_rd = '0;

    fifo_replacement_cache_top dut (.*);

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Empty the shadow cache and zero both counters
    function automatic void empty_cache();
        for (int i = 0; i < NUM_SLOTS; i++) begin
            model_used[i] = 1'b0;
            model_keys[i] = '0;
            model_data[i] = '0;
        end
        model_head   = 0;
        model_fill   = 0;
        model_hits   = '0;
        model_misses = '0;
    endfunction

    function automatic int find_slot(logic [31:0] key);
        for (int i = 0; i < NUM_SLOTS; i++)
            if (model_used[i] && model_keys[i] == key)
                return i;
        return -1;
    endfunction

    // Apply one word to the shadow cache and return the result it produces
    function automatic t_cache_result cache_predict(logic [KIND_W-1:0] kind, logic [31:0] key,
                                                    logic [31:0] din);
        t_cache_result res;
        int            slot;
        int unsigned   limit;
        int unsigned   pos;
        res   = '0;
        slot  = find_slot(key);
        limit = (model_capacity == 0) ? 1 :
                (model_capacity > NUM_SLOTS) ? NUM_SLOTS : model_capacity;
        case (kind)
            KIND_LOOKUP: begin
                if (slot >= 0) begin
                    res.hit       = 1'b1;
                    res.read_data = model_data[slot];
                    if (model_hits != '1)
                        model_hits++;
                end else if (model_misses != '1) begin
                    model_misses++;
                end
            end
            KIND_LOAD: begin
                if (slot >= 0) begin
                    // update in place, queue order unchanged
                    model_data[slot] = din;
                end else begin
                    // drop exactly one oldest entry once the fill reaches the capacity
                    if (model_fill >= limit && model_fill > 0) begin
                        res.evicted            = 1'b1;
                        res.evicted_key        = model_keys[model_head];
                        model_used[model_head] = 1'b0;
                        model_head             = (model_head + 1) % NUM_SLOTS;
                        model_fill--;
                    end
                    pos             = (model_head + model_fill) % NUM_SLOTS;
                    model_keys[pos] = key;
                    model_data[pos] = din;
                    model_used[pos] = 1'b1;
                    model_fill++;
                end
            end
            KIND_CLEAR: empty_cache();
            default: ;
        endcase
        res.hit_count  = model_hits;
        res.miss_count = model_misses;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s mismatch, got %h expected %h", $time, what, got, want);
        error_count++;
    endtask

    // Offer one word and hold it until accepted; leave tvalid high on return
    task automatic send_word(input logic [KIND_W-1:0] kind, input logic [31:0] key,
                             input logic [31:0] din);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = kind;
        i_s_axis_tdata  = {din, key};
        forever begin
            @(posedge i_clk);
            if (o_s_axis_tready)
                break;
        end
        pred_buf[pred_wr] = cache_predict(kind, key, din);
        pred_wr           = pred_wr + 1'b1;
        @(negedge i_clk);
    endtask

    task automatic pause_sender(input int cycles);
        i_s_axis_tvalid = 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // Write the capacity once every outstanding result has drained
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        i_s_axis_tvalid = 1'b0;
        while (pred_wr != pred_rd)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready)
                break;
        end
        model_capacity = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic test_empty_lookups();
        send_word(KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_word(KIND_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(KIND_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // Update of a present key must not move it in the queue
    task automatic test_update_and_evict();
        write_capacity(5'd2);
        send_word(KIND_LOAD, 32'h0000_0000, 32'h0000_0000);
        send_word(KIND_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(KIND_LOAD, 32'h0000_0000, 32'h5A5A_A5A5);
        send_word(KIND_LOAD, 32'h1234_5678, 32'h8765_4321);
        send_word(KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_word(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        send_word(KIND_LOOKUP, 32'h1234_5678, 32'h0000_0000);
    endtask

    task automatic test_clear();
        send_word(KIND_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    endtask

    // Zero acts as one, values above the store size clamp, shrinking keeps the fill
    task automatic test_capacity_limits();
        write_capacity(5'd0);
        send_word(KIND_LOAD, 32'hA000_0001, 32'h0000_0011);
        send_word(KIND_LOAD, 32'hB000_0002, 32'h0000_0022);
        send_word(KIND_LOOKUP, 32'hB000_0002, 32'h0000_0000);
        write_capacity(5'd31);
        send_word(KIND_LOAD, 32'hC000_0003, 32'h0000_0033);
        send_word(KIND_LOAD, 32'hD000_0004, 32'h0000_0044);
        send_word(KIND_LOAD, 32'hE000_0005, 32'h0000_0055);
        write_capacity(5'd1);
        send_word(KIND_LOAD, 32'hF000_0006, 32'h0000_0066);
        send_word(KIND_LOOKUP, 32'hC000_0003, 32'h0000_0000);
        send_word(KIND_CLEAR, 32'h0000_0000, 32'h0000_0000);
    endtask

    // Bursty random traffic over a key pool, one capacity per phase
    task automatic test_random_traffic();
        logic [CAP_W-1:0]  phase_caps [9] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd3,
                                             5'd17, 5'd7, 5'd10, 5'd16};
        logic [31:0]       key_pool [POOL_SIZE];
        int                burst_left;
        int                pick;
        logic [KIND_W-1:0] kind;
        logic [31:0]       key;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom();
        burst_left = 0;
        foreach (phase_caps[p]) begin
            write_capacity(phase_caps[p]);
            // stall the output side for a while so the input backs up
            if (p == 1 || p == 5)
                hold_asked++;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 48);
                    if ($urandom_range(0, 3) != 0)
                        pause_sender($urandom_range(1, 9));
                end
                burst_left--;
                pick = $urandom_range(0, 99);
                kind = (pick < 50) ? KIND_LOOKUP :
                       (pick < 94) ? KIND_LOAD :
                       (pick < 97) ? KIND_NOP : KIND_CLEAR;
                key  = ($urandom_range(0, 9) != 0) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                   : $urandom();
                send_word(kind, key, $urandom());
            end
        end
    endtask

    // Output-side ready: changing patterns plus a requested long hold-off
    initial begin
        t_ready_mode mode;
        int          span;
        i_m_axis_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            mode = t_ready_mode'($urandom_range(0, 3));
            span = $urandom_range(8, 80);
            for (int c = 0; c < span; c++) begin
                @(negedge i_clk);
                if (hold_served != hold_asked) begin
                    i_m_axis_tready = 1'b0;
                    repeat (HOLD_CYCLES) @(negedge i_clk);
                    hold_served++;
                end
                case (mode)
                    READY_ALWAYS: i_m_axis_tready = 1'b1;
                    READY_MOSTLY: i_m_axis_tready = ($urandom_range(0, 9) < 7);
                    READY_SPARSE: i_m_axis_tready = ($urandom_range(0, 9) < 3);
                    default:      i_m_axis_tready = ((c % 4) != 3);
                endcase
            end
        end
    end

    // Compare each result word against the oldest expectation
    always @(posedge i_clk) begin
        t_cache_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pred_wr == pred_rd) begin
                report_mismatch("unexpected word", o_m_axis_tdata[31:0], '0);
            end else begin
                want    = pred_buf[pred_rd];
                pred_rd = pred_rd + 1'b1;
                if (o_m_axis_tuser[0] !== want.hit)
                    report_mismatch("hit", 32'(o_m_axis_tuser[0]), 32'(want.hit));
                if (o_m_axis_tuser[1] !== want.evicted)
                    report_mismatch("evicted", 32'(o_m_axis_tuser[1]), 32'(want.evicted));
                if (o_m_axis_tdata[31:0] !== want.read_data)
                    report_mismatch("read_data", o_m_axis_tdata[31:0], want.read_data);
                if (o_m_axis_tdata[63:32] !== want.evicted_key)
                    report_mismatch("evicted_key", o_m_axis_tdata[63:32], want.evicted_key);
                if (o_m_axis_tdata[95:64] !== want.hit_count)
                    report_mismatch("hit_count", o_m_axis_tdata[95:64], want.hit_count);
                if (o_m_axis_tdata[127:96] !== want.miss_count)
                    report_mismatch("miss_count", o_m_axis_tdata[127:96], want.miss_count);
            end
        end
    end

    initial begin
        #(5_000_000);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        model_capacity  = CAP_RESET;
        empty_cache();
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_lookups();
        test_update_and_evict();
        test_clear();
        test_capacity_limits();
        test_random_traffic();

        // drain outstanding results, then allow a few quiet cycles
        i_s_axis_tvalid = 1'b0;
        while (pred_wr != pred_rd)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES * 2) @(negedge i_clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
